### src/rpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_pkg: shared types and constants of the page allocator
// Request and result payloads, status and operation codes, and the command
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int unsigned PAGES      = 1024;
    localparam int unsigned COUNT_BITS = 16;
    localparam int unsigned PAGE_BITS  = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int unsigned FC_BITS    = $clog2(PAGES + 1);
    localparam int unsigned ADDR_BITS  = 32;
    localparam int unsigned OFFSET_BITS = 12;

    localparam logic [FC_BITS-1:0]    PAGES_FC   = FC_BITS'(PAGES);
    localparam logic [ADDR_BITS-OFFSET_BITS:0] PAGES_CMP =
        (ADDR_BITS - OFFSET_BITS + 1)'(PAGES);
    localparam logic [PAGE_BITS-1:0]  LAST_PAGE  = PAGE_BITS'(PAGES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);

    typedef enum logic [1:0] {
        OP_SEED    = 2'd0,
        OP_ACQUIRE = 2'd1,
        OP_RELEASE = 2'd2,
        OP_GET     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_UNALIGNED = 3'd1,
        STS_RANGE     = 3'd2,
        STS_OVERFLOW  = 3'd3,
        STS_UNREF     = 3'd4,
        STS_NONE      = 3'd5,
        STS_FULL      = 3'd6
    } status_t;

    typedef struct packed {
        op_t                   operation;
        logic [ADDR_BITS-1:0]  page_address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  result_address;
        status_t               status;
    } out_item_t;

    typedef struct packed {
        op_t                   op;
        logic [ADDR_BITS-1:0]  addr;
        status_t               pre_status;
        logic [PAGE_BITS-1:0]  page;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_CNT_EXEC,
        BK_GET_CHECK,
        BK_STK_WAIT,
        BK_GET_CNT
    } back_state_t;

endpackage

### src/refcounted_page_allocator.sv
`timescale 1ns / 1ps
// The front end and the two-entry queue keep taking requests until the queue fills while the
// sequencer works; the sequencer carries out one command at a time, with one read port per table.
// Reset: synchronous, active low; afterwards a clearing pass over all PAGES (1024)
// entries zeroes the count table, and no request is taken until it finishes.
// ----------------------------------------------------------------------------
// refcounted_page_allocator: reference-counted physical page allocator
// Front end classifies requests, a short queue decouples it from the
// sequencer that updates the count table and the free page stack.
// ----------------------------------------------------------------------------
module refcounted_page_allocator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rpa_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output rpa_pkg::out_item_t m_item
);

    // The front end registers each request and settles the alignment and
    // range checks before the command enters the queue.
    logic          accept_en;
    logic          fq_push;
    logic          fq_ready;
    rpa_pkg::cmd_t fq_cmd;

    // Queue output toward the sequencer.
    logic          qb_valid;
    logic          qb_pop;
    rpa_pkg::cmd_t qb_cmd;

    rpa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept_en (accept_en),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .q_push    (fq_push),
        .q_cmd     (fq_cmd),
        .q_ready   (fq_ready)
    );

    // Two commands may wait here while the sequencer walks the stack.
    rpa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fq_push),
        .push_cmd   (fq_cmd),
        .push_ready (fq_ready),
        .pop        (qb_pop),
        .pop_valid  (qb_valid),
        .pop_cmd    (qb_cmd)
    );

    // The sequencer holds the result in its own register, so the queue
    // keeps filling while a finished result waits for m_ready.
    rpa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept_en (accept_en),
        .q_valid   (qb_valid),
        .q_cmd     (qb_cmd),
        .q_pop     (qb_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

### src/rpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_front: request intake and classification
// Registers each request, checks alignment and page range, and hands the
// resulting command to the queue.
// ----------------------------------------------------------------------------
module rpa_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept_en,
    input  logic             s_valid,
    output logic             s_ready,
    input  rpa_pkg::in_item_t s_item,
    output logic             q_push,
    output rpa_pkg::cmd_t    q_cmd,
    input  logic             q_ready
);

    logic          front_valid_reg, front_valid_next;
    rpa_pkg::cmd_t front_cmd_reg;
    rpa_pkg::cmd_t cmd_new;
    logic          take;

    always_comb begin
        cmd_new.op   = s_item.operation;
        cmd_new.addr = s_item.page_address;
        cmd_new.page = s_item.page_address[rpa_pkg::OFFSET_BITS +: rpa_pkg::PAGE_BITS];
        if (s_item.operation == rpa_pkg::OP_GET) begin
            cmd_new.pre_status = rpa_pkg::STS_OK;
        end else if (s_item.page_address[rpa_pkg::OFFSET_BITS-1:0] != '0) begin
            cmd_new.pre_status = rpa_pkg::STS_UNALIGNED;
        end else if ({1'b0, s_item.page_address[rpa_pkg::ADDR_BITS-1:rpa_pkg::OFFSET_BITS]}
                     >= rpa_pkg::PAGES_CMP) begin
            cmd_new.pre_status = rpa_pkg::STS_RANGE;
        end else begin
            cmd_new.pre_status = rpa_pkg::STS_OK;
        end
    end

    assign q_push  = front_valid_reg && q_ready;
    assign s_ready = accept_en && (!front_valid_reg || q_ready);
    assign take    = s_valid && s_ready;
    assign q_cmd   = front_cmd_reg;

    always_comb begin
        front_valid_next = front_valid_reg;
        if (take) begin
            front_valid_next = 1'b1;
        end else if (q_push) begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            front_cmd_reg <= cmd_new;
        end
    end

endmodule

### src/rpa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_queue: two-entry command queue
// Decouples the classifying front end from the back-end sequencer.
// ----------------------------------------------------------------------------
module rpa_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  rpa_pkg::cmd_t push_cmd,
    output logic          push_ready,
    input  logic          pop,
    output logic          pop_valid,
    output rpa_pkg::cmd_t pop_cmd
);

    rpa_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### src/rpa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_back: allocator sequencer
// Owns the reference count memory, the free page stack and the result
// register, and carries out one command at a time.
// ----------------------------------------------------------------------------
module rpa_back (
    input  logic              aclk,
    input  logic              aresetn,
    output logic              accept_en,
    input  logic              q_valid,
    input  rpa_pkg::cmd_t     q_cmd,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output rpa_pkg::out_item_t m_item
);

    localparam int unsigned PB = rpa_pkg::PAGE_BITS;
    localparam int unsigned CB = rpa_pkg::COUNT_BITS;
    localparam int unsigned FB = rpa_pkg::FC_BITS;

    logic [CB-1:0] cnt_mem [rpa_pkg::PAGES];
    logic [PB-1:0] stk_mem [rpa_pkg::PAGES];

    rpa_pkg::back_state_t state_reg, state_next;
    rpa_pkg::cmd_t        cmd_reg;
    logic [FB-1:0]        fc_reg, fc_next;
    logic [PB-1:0]        clr_idx_reg, clr_idx_next;
    logic [PB-1:0]        page_reg;
    logic [CB-1:0]        cnt_rd_reg;
    logic [PB-1:0]        stk_rd_reg;
    logic                 out_valid_reg, out_valid_next;
    rpa_pkg::out_item_t   out_reg, out_next;

    logic          out_free;
    logic          cnt_re, cnt_we, stk_re, stk_we;
    logic [PB-1:0] cnt_raddr, cnt_waddr, stk_waddr, stk_wdata;
    logic [CB-1:0] cnt_wdata;
    logic [FB-1:0] fc_dec;
    logic          cmd_load, page_load, load_out;
    logic          stack_full, stack_empty;

    assign out_free    = !out_valid_reg || m_ready;
    assign fc_dec      = fc_reg - FB'(1);
    assign stack_full  = (fc_reg == rpa_pkg::PAGES_FC);
    assign stack_empty = (fc_reg == '0);
    assign accept_en   = (state_reg != rpa_pkg::BK_CLEAR);
    assign m_valid     = out_valid_reg;
    assign m_item      = out_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rpa_pkg::BK_CLEAR: begin
                if (clr_idx_reg == rpa_pkg::LAST_PAGE) begin
                    state_next = rpa_pkg::BK_IDLE;
                end
            end
            rpa_pkg::BK_IDLE: begin
                if (q_valid && q_cmd.pre_status == rpa_pkg::STS_OK) begin
                    if (q_cmd.op == rpa_pkg::OP_ACQUIRE || q_cmd.op == rpa_pkg::OP_RELEASE) begin
                        state_next = rpa_pkg::BK_CNT_EXEC;
                    end else if (q_cmd.op == rpa_pkg::OP_GET) begin
                        state_next = rpa_pkg::BK_GET_CHECK;
                    end
                end
            end
            rpa_pkg::BK_CNT_EXEC: begin
                if (out_free) begin
                    state_next = rpa_pkg::BK_IDLE;
                end
            end
            rpa_pkg::BK_GET_CHECK: begin
                if (!stack_empty) begin
                    state_next = rpa_pkg::BK_STK_WAIT;
                end else if (out_free) begin
                    state_next = rpa_pkg::BK_IDLE;
                end
            end
            rpa_pkg::BK_STK_WAIT: begin
                state_next = rpa_pkg::BK_GET_CNT;
            end
            rpa_pkg::BK_GET_CNT: begin
                if (cnt_rd_reg != '0) begin
                    state_next = rpa_pkg::BK_GET_CHECK;
                end else if (out_free) begin
                    state_next = rpa_pkg::BK_IDLE;
                end
            end
            default: state_next = rpa_pkg::BK_CLEAR;
        endcase
    end

    // Datapath controls.
    always_comb begin
        q_pop        = 1'b0;
        cnt_re       = 1'b0;
        cnt_raddr    = q_cmd.page;
        cnt_we       = 1'b0;
        cnt_waddr    = cmd_reg.page;
        cnt_wdata    = '0;
        stk_re       = 1'b0;
        stk_we       = 1'b0;
        stk_waddr    = fc_reg[PB-1:0];
        stk_wdata    = cmd_reg.page;
        fc_next      = fc_reg;
        clr_idx_next = clr_idx_reg;
        cmd_load     = 1'b0;
        page_load    = 1'b0;
        load_out     = 1'b0;
        out_next     = out_reg;
        unique case (state_reg)
            rpa_pkg::BK_CLEAR: begin
                cnt_we       = 1'b1;
                cnt_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + PB'(1);
            end
            rpa_pkg::BK_IDLE: begin
                if (q_valid) begin
                    if (q_cmd.pre_status != rpa_pkg::STS_OK) begin
                        if (out_free) begin
                            q_pop    = 1'b1;
                            load_out = 1'b1;
                            out_next = '{result_address: q_cmd.addr,
                                         status: q_cmd.pre_status};
                        end
                    end else begin
                        unique case (q_cmd.op)
                            rpa_pkg::OP_SEED: begin
                                if (out_free) begin
                                    q_pop    = 1'b1;
                                    load_out = 1'b1;
                                    out_next.result_address = q_cmd.addr;
                                    if (stack_full) begin
                                        out_next.status = rpa_pkg::STS_FULL;
                                    end else begin
                                        out_next.status = rpa_pkg::STS_OK;
                                        stk_we    = 1'b1;
                                        stk_wdata = q_cmd.page;
                                        fc_next   = fc_reg + FB'(1);
                                    end
                                end
                            end
                            rpa_pkg::OP_ACQUIRE, rpa_pkg::OP_RELEASE: begin
                                q_pop    = 1'b1;
                                cmd_load = 1'b1;
                                cnt_re   = 1'b1;
                            end
                            rpa_pkg::OP_GET: begin
                                q_pop    = 1'b1;
                                cmd_load = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            rpa_pkg::BK_CNT_EXEC: begin
                if (out_free) begin
                    load_out = 1'b1;
                    out_next.result_address = cmd_reg.addr;
                    out_next.status         = rpa_pkg::STS_OK;
                    if (cmd_reg.op == rpa_pkg::OP_ACQUIRE) begin
                        if (cnt_rd_reg == rpa_pkg::COUNT_MAX) begin
                            out_next.status = rpa_pkg::STS_OVERFLOW;
                        end else begin
                            cnt_we    = 1'b1;
                            cnt_wdata = cnt_rd_reg + CB'(1);
                        end
                    end else if (cnt_rd_reg == '0) begin
                        out_next.status = rpa_pkg::STS_UNREF;
                    end else begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_rd_reg - CB'(1);
                        if (cnt_rd_reg == rpa_pkg::COUNT_ONE) begin
                            if (stack_full) begin
                                out_next.status = rpa_pkg::STS_FULL;
                            end else begin
                                stk_we  = 1'b1;
                                fc_next = fc_reg + FB'(1);
                            end
                        end
                    end
                end
            end
            rpa_pkg::BK_GET_CHECK: begin
                if (!stack_empty) begin
                    stk_re = 1'b1;
                end else if (out_free) begin
                    load_out = 1'b1;
                    out_next = '{result_address: '0, status: rpa_pkg::STS_NONE};
                end
            end
            rpa_pkg::BK_STK_WAIT: begin
                cnt_re    = 1'b1;
                cnt_raddr = stk_rd_reg;
                page_load = 1'b1;
            end
            rpa_pkg::BK_GET_CNT: begin
                if (cnt_rd_reg != '0) begin
                    fc_next = fc_dec;
                end else if (out_free) begin
                    fc_next   = fc_dec;
                    cnt_we    = 1'b1;
                    cnt_waddr = page_reg;
                    cnt_wdata = rpa_pkg::COUNT_ONE;
                    load_out  = 1'b1;
                    out_next.result_address =
                        rpa_pkg::ADDR_BITS'({page_reg, {rpa_pkg::OFFSET_BITS{1'b0}}});
                    out_next.status = rpa_pkg::STS_OK;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rpa_pkg::BK_CLEAR;
            fc_reg        <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fc_reg        <= fc_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_load) begin
            cmd_reg <= q_cmd;
        end
        if (page_load) begin
            page_reg <= stk_rd_reg;
        end
        if (load_out) begin
            out_reg <= out_next;
        end
    end

    // Reference count memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            cnt_rd_reg <= cnt_mem[cnt_raddr];
        end
    end

    // Free page stack: the read always targets the top entry.
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            stk_rd_reg <= stk_mem[fc_dec[PB-1:0]];
        end
    end

endmodule

### src/rpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_checker: port-level checks of the page allocator
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module rpa_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input rpa_pkg::in_item_t  s_item,
    input logic               m_valid,
    input logic               m_ready,
    input rpa_pkg::out_item_t m_item
);

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // The clearing pass blocks requests right after reset.
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("request taken during count clear");

    // No free page reports a zero address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == rpa_pkg::STS_NONE |-> m_item.result_address == '0)
        else $error("none-free result with nonzero address");

    // Unaligned status only for addresses with offset bits set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == rpa_pkg::STS_UNALIGNED
        |-> m_item.result_address[rpa_pkg::OFFSET_BITS-1:0] != '0)
        else $error("unaligned status on aligned address");

    // Every successful result names an aligned page address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == rpa_pkg::STS_OK
        |-> m_item.result_address[rpa_pkg::OFFSET_BITS-1:0] == '0)
        else $error("ok result with unaligned address");

endmodule

bind refcounted_page_allocator rpa_checker u_checker (.*);
